// File: hdl/clcd_pkg.sv
package clcd_pkg;

  localparam int TEXT_ROWS   = 4;
  localparam int MAX_COLUMNS = 40;
  localparam int STORE_DEPTH = TEXT_ROWS * MAX_COLUMNS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam logic [6:0] ADDR_WRAP  = 7'h68;
  localparam logic [6:0] LINE0_END  = 7'h28;
  localparam logic [6:0] LINE1_BASE = 7'h40;
  localparam logic [5:0] FOLD_COL   = 6'd20;
  localparam logic [2:0] FOLD_ROWS  = 3'd4;
  localparam logic [5:0] COLS_RESET = 6'd20;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [8:0] ACC_EMPTY  = 9'h001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] bus_byte;
    logic [1:0] read_row;
    logic [5:0] read_col;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       display_on;
    logic [5:0] column_count;
    logic [6:0] cursor_address;
  } res_t;

  function automatic logic [IDX_W-1:0] cell_index(input logic [1:0] row,
                                                  input logic [5:0] col);
    cell_index = IDX_W'(IDX_W'(row) * IDX_W'(MAX_COLUMNS)) + IDX_W'(col);
  endfunction

  function automatic logic cell_in_range(input logic [1:0] row, input logic [5:0] col);
    cell_in_range = ({1'b0, row} < 3'(TEXT_ROWS)) && (col < 6'(MAX_COLUMNS));
  endfunction

endpackage

// File: hdl/char_lcd_4bit_backpack_emulator_core.sv
// Channel   Ports                              Handshake
// request   start, busy, req_i                 taken when start && !busy
// result    done_o, res_o                      one-cycle strobe, no stall
// config    cfg_we_i, cfg_wdata_i              written when cfg_we_i
//
// Expander byte: result strobed the cycle after the request, unless it starts a clear.
// Cell read: the registered text RAM read lands in ST_READ, which registers the result.
// Clear command: ST_CLEAR writes all STORE_DEPTH RAM entries, one RAM entry per cycle.
// After reset the store reads as zero through per-entry valid bits.
// The receiver cannot stall; busy only covers cell reads and clears.
module char_lcd_4bit_backpack_emulator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  clcd_pkg::req_t     req_i,
  output logic               done_o,
  output clcd_pkg::res_t     res_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i
);

  localparam int IW = clcd_pkg::IDX_W;

  clcd_pkg::state_e state_q, state_d;

  logic [2:0]  row_cnt_q;
  logic [6:0]  ddram_q, ddram_d;
  logic [8:0]  acc_q, acc_d;
  logic        rs_q, rs_d;
  logic [5:0]  cols_q, cols_d;
  logic        bl_q, bl_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [clcd_pkg::STORE_DEPTH-1:0] valid_q;
  logic        rd_ok_q, rd_ok_d;
  logic        vld_rd_q, vld_rd_d;
  clcd_pkg::res_t res_q, res_d;
  logic        done_q, done_d;

  logic        accept;
  logic        clear_go;
  logic        wr_go;
  logic [IW-1:0] wr_idx;
  logic [7:0]  wr_data;
  logic [IW-1:0] rd_idx;
  logic        rd_ok;
  logic [8:0]  acc_base, acc_n;
  logic [6:0]  a1, a2;
  logic [5:0]  dcol;
  logic [1:0]  drow;
  logic [5:0]  ncol;
  logic [7:0]  cbyte;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign accept = start && !busy;
  assign rd_idx = clcd_pkg::cell_index(req_i.read_row, req_i.read_col);
  assign rd_ok  = clcd_pkg::cell_in_range(req_i.read_row, req_i.read_col);

  // byte decode, read and clear results, and register update
  always_comb begin
    ddram_d  = ddram_q;
    acc_d    = acc_q;
    rs_d     = rs_q;
    cols_d   = cols_q;
    bl_d     = bl_q;
    clr_d    = clr_q;
    rd_ok_d  = rd_ok_q;
    vld_rd_d = vld_rd_q;
    res_d    = res_q;
    done_d   = 1'b0;
    clear_go = 1'b0;
    wr_go    = 1'b0;
    acc_base = acc_q;
    acc_n    = acc_q;
    wr_data  = acc_n[7:0];
    cbyte    = acc_n[7:0];
    a1       = (ddram_q >= clcd_pkg::ADDR_WRAP) ? 7'd0 : ddram_q;
    a2       = (a1 >= clcd_pkg::LINE0_END && a1 < clcd_pkg::LINE1_BASE) ?
               clcd_pkg::LINE1_BASE : a1;
    dcol     = a2[5:0];
    drow     = {1'b0, a2[6]};
    if (row_cnt_q == clcd_pkg::FOLD_ROWS && dcol >= clcd_pkg::FOLD_COL) begin
      dcol = dcol - clcd_pkg::FOLD_COL;
      drow = drow + 2'd2;
    end
    wr_idx = clcd_pkg::cell_index(drow, dcol);
    ncol   = (dcol >= 6'(clcd_pkg::MAX_COLUMNS)) ? 6'(clcd_pkg::MAX_COLUMNS) : dcol + 6'd1;

    if (accept && !req_i.cmd) begin
      if (req_i.bus_byte[2:1] == 2'b10) begin
        bl_d = req_i.bus_byte[3];
        rs_d = req_i.bus_byte[0];
        if (rs_d != rs_q) begin
          acc_base = clcd_pkg::ACC_EMPTY;
        end
        acc_n = {acc_base[4:0], req_i.bus_byte[7:4]};
        acc_d = acc_n;
        cbyte = acc_n[7:0];
        if (acc_n[8]) begin
          acc_d = clcd_pkg::ACC_EMPTY;
          if (rs_d) begin
            wr_data = cbyte;
            wr_go   = clcd_pkg::cell_in_range(drow, dcol);
            ddram_d = a2 + 7'd1;
            if (dcol >= cols_q) begin
              cols_d = ncol;
            end
          end else if (cbyte[7]) begin
            ddram_d = cbyte[6:0];
          end else if (cbyte[6] || (cbyte[5:2] != 4'd0)) begin
            ddram_d = ddram_q;
          end else if (cbyte[1]) begin
            ddram_d = 7'd0;
          end else if (cbyte[0]) begin
            ddram_d  = 7'd0;
            clear_go = 1'b1;
            clr_d    = '0;
          end
        end
      end
      res_d  = '{cell_char: 8'd0, display_on: bl_d, column_count: cols_d,
                 cursor_address: ddram_d};
      done_d = !clear_go;
    end

    if (accept && req_i.cmd) begin
      rd_ok_d  = rd_ok;
      vld_rd_d = rd_ok ? valid_q[rd_idx] : 1'b0;
    end

    if (state_q == clcd_pkg::ST_READ) begin
      res_d  = '{cell_char: (rd_ok_q && vld_rd_q) ? ram_rdata : 8'd0,
                 display_on: bl_q, column_count: cols_q, cursor_address: ddram_q};
      done_d = 1'b1;
    end

    if (state_q == clcd_pkg::ST_CLEAR) begin
      clr_d = clr_q + IW'(1);
      if (clr_q == IW'(clcd_pkg::STORE_DEPTH - 1)) begin
        res_d  = '{cell_char: 8'd0, display_on: bl_q, column_count: cols_q,
                   cursor_address: ddram_q};
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clcd_pkg::ST_IDLE: begin
        if (accept && req_i.cmd) begin
          state_d = clcd_pkg::ST_READ;
        end else if (clear_go) begin
          state_d = clcd_pkg::ST_CLEAR;
        end
      end
      clcd_pkg::ST_READ: begin
        state_d = clcd_pkg::ST_IDLE;
      end
      clcd_pkg::ST_CLEAR: begin
        if (clr_q == IW'(clcd_pkg::STORE_DEPTH - 1)) begin
          state_d = clcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = wr_data;
    unique case (state_q)
      clcd_pkg::ST_IDLE: begin
        busy   = 1'b0;
        ram_we = wr_go;
      end
      clcd_pkg::ST_READ: begin
        busy = 1'b1;
      end
      clcd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = clcd_pkg::CHAR_SPACE;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  clcd_ram #(
    .WIDTH(8),
    .DEPTH(clcd_pkg::STORE_DEPTH)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clcd_pkg::ST_IDLE;
      row_cnt_q <= clcd_pkg::FOLD_ROWS;
      ddram_q   <= 7'd0;
      acc_q     <= clcd_pkg::ACC_EMPTY;
      rs_q      <= 1'b0;
      cols_q    <= clcd_pkg::COLS_RESET;
      bl_q      <= 1'b0;
      clr_q     <= '0;
      valid_q   <= '0;
      rd_ok_q   <= 1'b0;
      vld_rd_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      ddram_q  <= ddram_d;
      acc_q    <= acc_d;
      rs_q     <= rs_d;
      cols_q   <= cols_d;
      bl_q     <= bl_d;
      clr_q    <= clr_d;
      rd_ok_q  <= rd_ok_d;
      vld_rd_q <= vld_rd_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        row_cnt_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hdl/clcd_ram.sv
module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/clcd_checker.sv
module clcd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input clcd_pkg::req_t req_i,
  input logic           done_o,
  input clcd_pkg::res_t res_o
);

  a_cols_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.column_count <= 6'(clcd_pkg::MAX_COLUMNS)))
    else $error("column count above cap");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.cmd) |=> ##1 done_o)
    else $error("cell read result not in two cycles");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && !req_i.cmd)) |-> (res_o.cell_char == 8'd0))
    else $error("byte request returned nonzero cell");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start && !busy)))
    else $error("result without request");

  a_byte_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !req_i.cmd) |=> (done_o || busy))
    else $error("byte request dropped");

endmodule

bind char_lcd_4bit_backpack_emulator_core clcd_checker u_clcd_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .res_o (res_o)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import clcd_pkg::*;

  // expander byte bit positions
  localparam int BIT_RS = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_EN = 2;
  localparam int BIT_BL = 3;

  // controller commands
  localparam logic [7:0] CMD_NOP       = 8'h00;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
  localparam int PHASE_ITEMS  = 60;

  class lcd_scoreboard;
    logic [7:0] cells [STORE_DEPTH];
    logic [6:0] ddram;
    logic [8:0] nibbles;
    logic       rs_q;
    logic [5:0] cols;
    logic       backlight;
    logic [2:0] rows;
    res_t       pending [$];
    int         errors;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      ddram     = '0;
      nibbles   = ACC_EMPTY;
      rs_q      = 1'b0;
      cols      = COLS_RESET;
      backlight = 1'b0;
      rows      = FOLD_ROWS;
      errors    = 0;
    endfunction

    function void note_request(req_t r);
      res_t       e;
      logic [7:0] v;
      int         col;
      int         row;
      e = '0;
      if (r.cmd) begin
        if (int'(r.read_row) < TEXT_ROWS && int'(r.read_col) < MAX_COLUMNS)
          e.cell_char = cells[int'(r.read_row) * MAX_COLUMNS + int'(r.read_col)];
      end else if (r.bus_byte[BIT_EN] && !r.bus_byte[BIT_RW]) begin
        backlight = r.bus_byte[BIT_BL];
        if (r.bus_byte[BIT_RS] != rs_q) begin
          rs_q    = r.bus_byte[BIT_RS];
          nibbles = ACC_EMPTY;
        end
        nibbles = {nibbles[4:0], r.bus_byte[7:4]};
        if (nibbles[8]) begin
          v       = nibbles[7:0];
          nibbles = ACC_EMPTY;
          if (rs_q) begin
            if (ddram >= ADDR_WRAP) ddram = '0;
            if (ddram >= LINE0_END && ddram < LINE1_BASE) ddram = LINE1_BASE;
            col = int'(ddram[5:0]);
            row = int'(ddram[6]);
            if (rows == FOLD_ROWS && col >= int'(FOLD_COL)) begin
              col -= int'(FOLD_COL);
              row += 2;
            end
            if (row < TEXT_ROWS && col < MAX_COLUMNS) cells[row * MAX_COLUMNS + col] = v;
            ddram = ddram + 7'd1;
            if (col >= int'(cols)) cols = 6'((col + 1 > MAX_COLUMNS) ? MAX_COLUMNS : col + 1);
          end else if ((v & CMD_SET_DDRAM) != 0) begin
            ddram = v[6:0];
          end else if ((v & CMD_CGRAM) != 0 || (v & 8'h3c) != 0) begin
            // CGRAM address, function set, shift, display control, entry mode
          end else if ((v & CMD_HOME) != 0) begin
            ddram = '0;
          end else if ((v & CMD_CLEAR) != 0) begin
            foreach (cells[i]) cells[i] = CHAR_SPACE;
            ddram = '0;
          end
        end
      end
      e.display_on     = backlight;
      e.column_count   = cols;
      e.cursor_address = ddram;
      pending.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cell_char !== e.cell_char) begin
        $error("cell_char: expected %0h, got %0h", e.cell_char, got.cell_char);
        errors++;
      end
      if (got.display_on !== e.display_on) begin
        $error("display_on: expected %0h, got %0h", e.display_on, got.display_on);
        errors++;
      end
      if (got.column_count !== e.column_count) begin
        $error("column_count: expected %0d, got %0d", e.column_count, got.column_count);
        errors++;
      end
      if (got.cursor_address !== e.cursor_address) begin
        $error("cursor_address: expected %0h, got %0h", e.cursor_address, got.cursor_address);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       done_o;
  res_t       res_o;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  lcd_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   sent_items;

  char_lcd_4bit_backpack_emulator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic req_t bus_req(input logic [7:0] b);
    req_t r;
    r.cmd      = 1'b0;
    r.bus_byte = b;
    r.read_row = 2'($urandom);
    r.read_col = 6'($urandom);
    return r;
  endfunction

  function automatic req_t read_req(input logic [1:0] row, input logic [5:0] col);
    req_t r;
    r.cmd      = 1'b1;
    r.bus_byte = 8'($urandom);
    r.read_row = row;
    r.read_col = col;
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    sent_items++;
  endtask

  task automatic send_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] b;
    b = {nib, 4'b0000};
    b[BIT_BL] = 1'($urandom_range(1));
    b[BIT_EN] = 1'b1;
    b[BIT_RS] = rs;
    send_req(bus_req(b));
    if ($urandom_range(99) < 30) begin
      b[BIT_EN] = 1'b0;
      send_req(bus_req(b));
    end
  endtask

  task automatic send_byte(input logic [7:0] v, input logic rs);
    send_nibble(v[7:4], rs);
    send_nibble(v[3:0], rs);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rows(input logic [2:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rows = v;
  endtask

  task automatic random_transaction();
    int unsigned pick;
    logic [6:0]  a;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_byte(8'($urandom), 1'b1);
    end else if (pick < 57) begin
      case ($urandom_range(3))
        0:       a = 7'($urandom_range(7'h27));
        1:       a = 7'($urandom_range(7'h3f, 7'h28));
        2:       a = 7'($urandom_range(7'h67, 7'h40));
        default: a = 7'($urandom_range(7'h7f, 7'h68));
      endcase
      send_byte(CMD_SET_DDRAM | {1'b0, a}, 1'b0);
    end else if (pick < 61) begin
      c = 8'($urandom_range(8'h7f));
      if (c == CMD_CLEAR) c = CMD_HOME;
      send_byte(c, 1'b0);
    end else if (pick < 63) begin
      send_byte(CMD_CLEAR, 1'b0);
    end else if (pick < 88) begin
      send_req(read_req(2'($urandom),
                        6'(($urandom_range(99) < 85) ? $urandom_range(39)
                                                     : $urandom_range(63, 40))));
    end else if (pick < 94) begin
      send_req(bus_req(8'($urandom)));
    end else begin
      // lone nibble: leaves a half byte or breaks one on register select change
      send_nibble(4'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [2:0] phase_rows [6];
    phase_rows = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3};
    sb           = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    idle_pct     = 20;
    sent_items   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_rows(FOLD_ROWS);

    send_req(read_req(2'd3, 6'd39));
    send_req(read_req(2'd2, 6'd63));
    send_req(bus_req(8'hfe));           // read/write set
    send_req(bus_req(8'hf9));           // enable clear
    send_byte(CMD_NOP, 1'b0);
    send_nibble(4'h5, 1'b1);            // half data byte, dropped by the command below
    send_byte(CMD_SET_DDRAM | 8'h7f, 1'b0);
    send_byte(8'h5a, 1'b1);             // address wraps to zero
    send_byte(CMD_SET_DDRAM | 8'h30, 1'b0);
    send_byte(8'ha5, 1'b1);             // jumps to second line
    send_byte(CMD_SET_DDRAM | 8'h14, 1'b0);
    send_byte(8'hc3, 1'b1);             // folded onto third row
    send_byte(CMD_CGRAM, 1'b0);
    send_byte(CMD_FUNC_SET, 1'b0);
    send_byte(CMD_CLEAR, 1'b0);
    send_byte(CMD_HOME, 1'b0);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_rows(phase_rows[p]);
      idle_pct   = (p < 2) ? 20 : (p < 4) ? 86 : 0;
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) random_transaction();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: char_lcd_4bit_backpack_emulator_core.f
hdl/clcd_pkg.sv
hdl/clcd_ram.sv
hdl/char_lcd_4bit_backpack_emulator_core.sv
hdl/clcd_checker.sv
dv/tb_top.sv
